/* hw/rtl/tce_pkg.sv */
`timescale 1ns / 1ps

package tce_pkg;

    // longest recording in samples
    localparam int MAX_RECORD = 16384;

    // field widths fixed by the interface
    localparam int SAMPLE_W  = 16;
    localparam int IDX_W     = 14;
    localparam int RECLEN_W  = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // internal counter and length widths
    localparam int CNT_W = $clog2(MAX_RECORD);
    localparam int LEN_W = (CNT_W + 1 > RECLEN_W) ? CNT_W + 1 : RECLEN_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_THRESHOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LENGTH   = 2'd2;

    // reset values of the configuration registers
    localparam logic signed [SAMPLE_W-1:0] START_THRESHOLD_RST = 16'sd15000;
    localparam logic signed [SAMPLE_W-1:0] END_THRESHOLD_RST   = 16'sd14000;
    localparam logic [RECLEN_W-1:0]        RECORD_LENGTH_RST   = 15'd10000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] start_threshold;
        logic signed [SAMPLE_W-1:0] end_threshold;
        logic [RECLEN_W-1:0]        record_length;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]           record_index;
        logic signed [SAMPLE_W-1:0] recorded_value;
        logic                       last;
        logic                       end_found;
        logic [IDX_W-1:0]           end_index;
        logic [SAMPLE_W-1:0]        peak_magnitude;
    } result_t;

endpackage

/* hw/rtl/triggered_capture_endpointer.sv */
`timescale 1ns / 1ps
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-----------------------------------------
// input    | in        | in_valid / in_stall  | sample
// result   | out       | out_valid / out_stall| record_index, recorded_value, last,
//          |           |                      | end_found, end_index, peak_magnitude
// config   | in        | cfg_we               | cfg_index, cfg_data
//
// one sample per cycle sustained while no held result is stalled; a sample
// passes through the input register and then the result register
// armed samples and the trigger sample give no result; they leave the input
// register at the next edge unless a held result is stalled
// rst_n is asynchronous active low and clears control and capture state
// a stalled result holds the result register; input stalls only when the input
// register is full and the result register holds a stalled result

module triggered_capture_endpointer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [tce_pkg::SAMPLE_W-1:0] sample,
    input  logic                                cfg_we,
    input  logic [tce_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tce_pkg::CFG_W-1:0]           cfg_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tce_pkg::IDX_W-1:0]           record_index,
    output logic signed [tce_pkg::SAMPLE_W-1:0] recorded_value,
    output logic                                last,
    output logic                                end_found,
    output logic [tce_pkg::IDX_W-1:0]           end_index,
    output logic [tce_pkg::SAMPLE_W-1:0]        peak_magnitude
);
    import tce_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t out_res;
    logic    res_valid;
    logic    res_take;

    // configuration registers
    tce_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register and capture logic
    tce_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .res_take  (res_take),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    tce_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign record_index   = out_res.record_index;
    assign recorded_value = out_res.recorded_value;
    assign last           = out_res.last;
    assign end_found      = out_res.end_found;
    assign end_index      = out_res.end_index;
    assign peak_magnitude = out_res.peak_magnitude;

`ifndef SYNTH
    // summary fields stay zero before the final sample
    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (!end_found && end_index == '0 && peak_magnitude == '0))
        else $error("summary fields set on a non-final sample");

    // no end sample means index zero
    a_no_end_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last && !end_found) |-> (end_index == '0))
        else $error("end index set without an end sample");

    // peak never exceeds the magnitude of the most negative sample
    a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (peak_magnitude <= 16'd32768))
        else $error("peak magnitude out of range");

    // input stalls only while the result register is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with result register free");
`endif

endmodule

/* hw/rtl/tce_cfg_regs.sv */
`timescale 1ns / 1ps

module tce_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tce_pkg::CFG_W-1:0]      cfg_data,
    output tce_pkg::cfg_t                  cfg
);
    import tce_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register decode, unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_THRESHOLD: cfg_next.start_threshold = cfg_data;
                CFG_END_THRESHOLD:   cfg_next.end_threshold   = cfg_data;
                CFG_RECORD_LENGTH:   cfg_next.record_length   = cfg_data[RECLEN_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_threshold <= START_THRESHOLD_RST;
            cfg_reg.end_threshold   <= END_THRESHOLD_RST;
            cfg_reg.record_length   <= RECORD_LENGTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/tce_capture.sv */
`timescale 1ns / 1ps

module tce_capture (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tce_pkg::cfg_t                      cfg,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [tce_pkg::SAMPLE_W-1:0] sample,
    input  logic                               res_take,
    output logic                               res_valid,
    output tce_pkg::result_t                   res
);
    import tce_pkg::*;

    // input register
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;

    // capture state
    logic                       recording_reg;
    logic                       recording_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic signed [SAMPLE_W-1:0] high_reg;
    logic signed [SAMPLE_W-1:0] high_next;
    logic signed [SAMPLE_W-1:0] low_reg;
    logic signed [SAMPLE_W-1:0] low_next;
    logic [CNT_W-1:0]           endpos_reg;
    logic [CNT_W-1:0]           endpos_next;
    logic                       endseen_reg;
    logic                       endseen_next;

    logic                       advance;
    logic                       accept;
    logic [LEN_W-1:0]           len_raw;
    logic [LEN_W-1:0]           len_eff;
    logic [LEN_W-1:0]           idx_ext;
    logic [LEN_W-1:0]           endpos_ext;
    logic                       is_last;
    logic                       end_hit;
    logic signed [SAMPLE_W:0]   neg_low;
    logic signed [SAMPLE_W:0]   high_ext;
    logic signed [SAMPLE_W:0]   peak;

    // handshake: the held sample moves on when the result side can take it
    assign advance  = s1_valid_reg && res_take;
    assign in_stall = s1_valid_reg && !res_take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
        end
    end

    // effective length: zero acts as one, clamp at the maximum
    assign len_raw = LEN_W'(cfg.record_length);
    always_comb
    begin
        priority if (len_raw == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (len_raw > LEN_W'(MAX_RECORD))
        begin
            len_eff = LEN_W'(MAX_RECORD);
        end
        else
        begin
            len_eff = len_raw;
        end
    end

    assign idx_ext = LEN_W'(count_reg);
    assign is_last = (idx_ext + LEN_W'(1)) >= len_eff;
    assign end_hit = s1_sample_reg >= cfg.end_threshold;

    // next capture state
    always_comb
    begin
        recording_next = recording_reg;
        count_next     = count_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        endpos_next    = endpos_reg;
        endseen_next   = endseen_reg;
        if (advance)
        begin
            if (!recording_reg)
            begin
                if (s1_sample_reg >= cfg.start_threshold)
                begin
                    recording_next = 1'b1;
                    count_next     = '0;
                    high_next      = '0;
                    low_next       = '0;
                    endpos_next    = '0;
                    endseen_next   = 1'b0;
                end
            end
            else
            begin
                if (s1_sample_reg > high_reg)
                begin
                    high_next = s1_sample_reg;
                end
                if (s1_sample_reg < low_reg)
                begin
                    low_next = s1_sample_reg;
                end
                if (end_hit)
                begin
                    endpos_next  = count_reg;
                    endseen_next = 1'b1;
                end
                if (is_last)
                begin
                    recording_next = 1'b0;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recording_reg <= 1'b0;
            count_reg     <= '0;
            high_reg      <= '0;
            low_reg       <= '0;
            endpos_reg    <= '0;
            endseen_reg   <= 1'b0;
        end
        else
        begin
            recording_reg <= recording_next;
            count_reg     <= count_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            endpos_reg    <= endpos_next;
            endseen_reg   <= endseen_next;
        end
    end

    // peak magnitude over the whole recording, this sample included
    assign neg_low  = -{low_next[SAMPLE_W-1], low_next};
    assign high_ext = {high_next[SAMPLE_W-1], high_next};
    assign peak     = (neg_low > high_ext) ? neg_low : high_ext;

    assign endpos_ext = LEN_W'(endpos_next);

    // result item
    assign res_valid = advance && recording_reg;
    always_comb
    begin
        res.record_index   = idx_ext[IDX_W-1:0];
        res.recorded_value = s1_sample_reg;
        res.last           = is_last;
        res.end_found      = 1'b0;
        res.end_index      = '0;
        res.peak_magnitude = '0;
        if (is_last)
        begin
            res.end_found      = endseen_next;
            res.end_index      = endseen_next ? endpos_ext[IDX_W-1:0] : '0;
            res.peak_magnitude = peak[SAMPLE_W-1:0];
        end
    end

endmodule

/* hw/rtl/tce_out_stage.sv */
`timescale 1ns / 1ps

module tce_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  tce_pkg::result_t res,
    output logic             res_take,
    output logic             out_valid,
    input  logic             out_stall,
    output tce_pkg::result_t out_res
);
    import tce_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;

    // the register can load when empty or when its transfer completes
    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule
